### hdl/i2a_pkg.sv
// Shared types, constants and the digit-to-ASCII function of the integer formatter.
`timescale 1ns / 1ps

package i2a_pkg;

	// Conversion kinds
	localparam logic [2:0] K_SDEC = 3'd0;
	localparam logic [2:0] K_UDEC = 3'd1;
	localparam logic [2:0] K_LHEX = 3'd2;
	localparam logic [2:0] K_UHEX = 3'd3;
	localparam logic [2:0] K_PTR  = 3'd4;

	// Field widths
	localparam int KIND_W  = 3;
	localparam int VALUE_W = 64;
	localparam int CHAR_W  = 8;
	localparam int COUNT_W = 31;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Pointer text length in hex digits
	localparam int POINTER_HEX_DIGITS = 16;

	// Digit shift register: up to sixteen nibbles, left aligned
	localparam int DIG_MAX   = 16;
	localparam int DIG_W     = 4 * DIG_MAX;
	localparam int DIG_CNT_W = $clog2(DIG_MAX + 1);
	localparam int PTR_SHIFT = DIG_W - 4 * POINTER_HEX_DIGITS;
	localparam logic [DIG_CNT_W-1:0] HEX32_DIGITS = DIG_CNT_W'(8);
	localparam logic [DIG_CNT_W-1:0] PTR_DIGITS   = DIG_CNT_W'(POINTER_HEX_DIGITS);

	// Binary to BCD conversion
	localparam int BIN_W      = 32;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int BIT_CNT_W  = $clog2(BIN_W);
	localparam logic [DIG_CNT_W-1:0] DEC_DIGITS = DIG_CNT_W'(BCD_DIGITS);

	// Characters
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_STRIP,
		S_PREFIX,
		S_DIGITS
	} state_t;

	// Digit shift register control and status
	typedef struct packed {
		logic load;
		logic shift;
	} dig_ctl_t;

	typedef struct packed {
		logic [3:0] top;
		logic       one_left;
	} dig_sts_t;

	// Map one digit to its ASCII code
	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [3:0] nib, input logic upper);
		logic [CHAR_W-1:0] base;
		base = upper ? CH_UA : CH_LA;
		if (nib < 4'd10)
			return CH_ZERO + {4'b0000, nib};
		else
			return base + {4'b0000, nib} - 8'd10;
	endfunction

endpackage

### hdl/i2a_dabble.sv
// Bit-serial binary to BCD converter (shift and add three, one bit per cycle).
`timescale 1ns / 1ps

module i2a_dabble (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [i2a_pkg::BIN_W-1:0]   bin,
	output logic                        done,
	output logic [i2a_pkg::BCD_W-1:0]   bcd
);

	logic                            busy_q;
	logic                            done_q;
	logic [i2a_pkg::BIT_CNT_W-1:0]   cnt_q;
	logic [i2a_pkg::BIN_W-1:0]       bin_q;
	logic [i2a_pkg::BCD_W-1:0]       bcd_q;
	logic [i2a_pkg::BCD_W-1:0]       adj;

	// Add three to every digit of five or more
	always_comb begin
		for (int i = 0; i < i2a_pkg::BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else
				adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == i2a_pkg::BIT_CNT_W'(i2a_pkg::BIN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift one binary bit into the BCD register per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[i2a_pkg::BIN_W-2:0], 1'b0};
			bcd_q <= {adj[i2a_pkg::BCD_W-2:0], bin_q[i2a_pkg::BIN_W-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

### hdl/i2a_digits.sv
// Nibble shift register that presents the text digits most significant first.
`timescale 1ns / 1ps

module i2a_digits (
	input  logic                          clk,
	input  logic                          arst_n,
	input  i2a_pkg::dig_ctl_t             ctl,
	input  logic [i2a_pkg::DIG_W-1:0]     load_data,
	input  logic [i2a_pkg::DIG_CNT_W-1:0] load_count,
	output i2a_pkg::dig_sts_t             sts
);

	logic [i2a_pkg::DIG_W-1:0]     sreg_q;
	logic [i2a_pkg::DIG_CNT_W-1:0] ndig_q;

	// Digit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ndig_q <= '0;
		end else if (ctl.load) begin
			ndig_q <= load_count;
		end else if (ctl.shift) begin
			ndig_q <= ndig_q - 1'b1;
		end
	end

	// Load left aligned, advance one nibble per shift
	always_ff @(posedge clk) begin
		if (ctl.load)
			sreg_q <= load_data;
		else if (ctl.shift)
			sreg_q <= {sreg_q[i2a_pkg::DIG_W-5:0], 4'h0};
	end

	assign sts.top      = sreg_q[i2a_pkg::DIG_W-1 -: 4];
	assign sts.one_left = (ndig_q == i2a_pkg::DIG_CNT_W'(1));

endmodule

### hdl/integer_to_ascii_formatter.sv
// Top level of the integer formatter: sequencer, prefix, output register and count.
//
//   channel  signals                          direction  payload
//   in       in_valid / in_ready              input      kind, value
//   out      out_valid / out_ready            output     character, last, running_count
//
// Hex kinds: accept, then a strip state that tests the top digit and drops each leading
//   zero, then emit the characters; a pointer carries a 0x prefix.
// Decimal kinds: accept, bit-serial BCD conversion and load of the digit register, then
//   the same strip and emit, with a minus sign first for a negative signed value.
// A new request is taken only once the previous item's last character sits in the
//   output register; that register lets the next request start while it waits.
// Output stalls hold the sequencer while it emits; reset clears control state and the count.
`timescale 1ns / 1ps

module integer_to_ascii_formatter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [i2a_pkg::KIND_W-1:0]    kind,
	input  logic [i2a_pkg::VALUE_W-1:0]   value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [i2a_pkg::CHAR_W-1:0]    character,
	output logic                          last,
	output logic [i2a_pkg::COUNT_W-1:0]   running_count
);

	i2a_pkg::state_t                state_q, state_d;
	logic                           accept;
	logic                           emit_ok;
	logic [i2a_pkg::BIN_W-1:0]      low;
	logic [i2a_pkg::BIN_W-1:0]      mag;
	logic                           dab_start;
	logic                           dab_done;
	logic [i2a_pkg::BCD_W-1:0]      bcd;
	i2a_pkg::dig_ctl_t              dig_ctl;
	i2a_pkg::dig_sts_t              dig_sts;
	logic [i2a_pkg::DIG_W-1:0]      dig_data;
	logic [i2a_pkg::DIG_CNT_W-1:0]  dig_count;
	logic                           out_load;
	logic [i2a_pkg::CHAR_W-1:0]     out_char;
	logic                           out_last;
	logic                           pre_shift;
	logic [2*i2a_pkg::CHAR_W-1:0]   pre_q;
	logic [1:0]                     pre_n_q;
	logic                           upper_q;
	logic                           out_valid_q;
	logic [i2a_pkg::CHAR_W-1:0]     char_q;
	logic                           last_q;
	logic [i2a_pkg::COUNT_W-1:0]    count_q;

	assign in_ready = (state_q == i2a_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;
	assign emit_ok  = !out_valid_q || out_ready;
	assign low      = value[i2a_pkg::BIN_W-1:0];
	assign mag      = (kind == i2a_pkg::K_SDEC && low[i2a_pkg::BIN_W-1]) ?
	                  (i2a_pkg::BIN_W'(0) - low) : low;

	i2a_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dab_start),
		.bin    (mag),
		.done   (dab_done),
		.bcd    (bcd)
	);

	i2a_digits u_digits (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (dig_ctl),
		.load_data  (dig_data),
		.load_count (dig_count),
		.sts        (dig_sts)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			i2a_pkg::S_IDLE: begin
				if (accept) begin
					case (kind)
						i2a_pkg::K_SDEC, i2a_pkg::K_UDEC:                 state_d = i2a_pkg::S_CONV;
						i2a_pkg::K_LHEX, i2a_pkg::K_UHEX, i2a_pkg::K_PTR: state_d = i2a_pkg::S_STRIP;
						default:                                           state_d = i2a_pkg::S_IDLE;
					endcase
				end
			end
			i2a_pkg::S_CONV: begin
				if (dab_done)
					state_d = i2a_pkg::S_STRIP;
			end
			i2a_pkg::S_STRIP: begin
				if (dig_sts.one_left || dig_sts.top != 4'h0)
					state_d = (pre_n_q != 2'd0) ? i2a_pkg::S_PREFIX : i2a_pkg::S_DIGITS;
			end
			i2a_pkg::S_PREFIX: begin
				if (emit_ok && pre_n_q == 2'd1)
					state_d = i2a_pkg::S_DIGITS;
			end
			i2a_pkg::S_DIGITS: begin
				if (emit_ok && dig_sts.one_left)
					state_d = i2a_pkg::S_IDLE;
			end
			default: state_d = i2a_pkg::S_IDLE;
		endcase
	end

	// Datapath control
	always_comb begin
		dab_start     = 1'b0;
		dig_ctl.load  = 1'b0;
		dig_ctl.shift = 1'b0;
		dig_data      = {low, {(i2a_pkg::DIG_W - i2a_pkg::BIN_W){1'b0}}};
		dig_count     = i2a_pkg::HEX32_DIGITS;
		out_load      = 1'b0;
		out_char      = pre_q[2*i2a_pkg::CHAR_W-1 -: i2a_pkg::CHAR_W];
		out_last      = 1'b0;
		pre_shift     = 1'b0;
		case (state_q)
			i2a_pkg::S_IDLE: begin
				if (accept) begin
					case (kind)
						i2a_pkg::K_SDEC, i2a_pkg::K_UDEC: dab_start = 1'b1;
						i2a_pkg::K_LHEX, i2a_pkg::K_UHEX: dig_ctl.load = 1'b1;
						i2a_pkg::K_PTR: begin
							dig_ctl.load = 1'b1;
							dig_data     = value << i2a_pkg::PTR_SHIFT;
							dig_count    = i2a_pkg::PTR_DIGITS;
						end
						default: dig_ctl.load = 1'b0;
					endcase
				end
			end
			i2a_pkg::S_CONV: begin
				dig_data  = {bcd, {(i2a_pkg::DIG_W - i2a_pkg::BCD_W){1'b0}}};
				dig_count = i2a_pkg::DEC_DIGITS;
				if (dab_done)
					dig_ctl.load = 1'b1;
			end
			i2a_pkg::S_STRIP: begin
				if (!dig_sts.one_left && dig_sts.top == 4'h0)
					dig_ctl.shift = 1'b1;
			end
			i2a_pkg::S_PREFIX: begin
				if (emit_ok) begin
					out_load  = 1'b1;
					pre_shift = 1'b1;
				end
			end
			i2a_pkg::S_DIGITS: begin
				out_char = i2a_pkg::digit_ascii(dig_sts.top, upper_q);
				out_last = dig_sts.one_left;
				if (emit_ok) begin
					out_load      = 1'b1;
					dig_ctl.shift = 1'b1;
				end
			end
			default: out_load = 1'b0;
		endcase
	end

	// State, prefix count, output valid and running count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= i2a_pkg::S_IDLE;
			pre_n_q     <= 2'd0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (kind == i2a_pkg::K_PTR)
					pre_n_q <= 2'd2;
				else if (kind == i2a_pkg::K_SDEC && low[i2a_pkg::BIN_W-1])
					pre_n_q <= 2'd1;
				else
					pre_n_q <= 2'd0;
			end else if (pre_shift) begin
				pre_n_q <= pre_n_q - 2'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (count_q != i2a_pkg::COUNT_MAX)
					count_q <= count_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Prefix characters, letter case and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			upper_q <= (kind == i2a_pkg::K_UHEX);
			if (kind == i2a_pkg::K_PTR)
				pre_q <= {i2a_pkg::CH_ZERO, i2a_pkg::CH_X};
			else
				pre_q <= {i2a_pkg::CH_MINUS, i2a_pkg::CHAR_W'(0)};
		end else if (pre_shift) begin
			pre_q <= {pre_q[i2a_pkg::CHAR_W-1:0], i2a_pkg::CHAR_W'(0)};
		end
		if (out_load) begin
			char_q <= out_char;
			last_q <= out_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign character     = char_q;
	assign last          = last_q;
	assign running_count = count_q;

`ifndef SYNTH
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= $past(count_q))
		else $error("running count decreased");

	a_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		dab_done |-> state_q == i2a_pkg::S_CONV)
		else $error("conversion finished outside conversion state");

	a_prefix_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == i2a_pkg::S_PREFIX |-> pre_n_q != 2'd0)
		else $error("prefix state with no prefix left");

	a_load_shift_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(dig_ctl.load && dig_ctl.shift))
		else $error("digit register loaded and shifted together");
`endif

endmodule
